FILE: hw/rtl/multi_reader_circular_fifo_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-reader circular FIFO core.
// Assertions compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_READER_CIRCULAR_FIFO_CORE_MACROS_SVH
`define MULTI_READER_CIRCULAR_FIFO_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge.
`define MRCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrcf: implication check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define MRCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrcf: next-cycle check failed");

`else

`define MRCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MRCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/mrcf_pkg.sv
// ----------------------------------------------------------------------------
// mrcf_pkg
// Types and codes shared by the multi-reader circular FIFO core.
// ----------------------------------------------------------------------------
package mrcf_pkg;

    localparam int OP_W      = 3;
    localparam int SLOT_W    = 3;
    localparam int FIELD_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int LEVEL_W   = 5;

    localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
    localparam logic [OP_W-1:0] OP_PEEK    = 3'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD     = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INACTIVE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [SLOT_W-1:0]  reader_slot;
        logic [FIELD_W-1:0] push_word;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                word_valid;
        logic [FIELD_W-1:0]  out_word;
        logic                tail_released;
        logic [LEVEL_W-1:0]  fill_level;
        logic                is_full;
        logic                is_empty;
    } rsp_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic commit;
    } ctl_cmd_t;

endpackage

FILE: hw/rtl/mrcf_ctrl.sv
// ----------------------------------------------------------------------------
// mrcf_ctrl
// Controller: sequences one transaction at a time through capture and
// execute, and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module mrcf_ctrl
    import mrcf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output ctl_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic slot_free;

    assign req_ready  = (state_reg == ST_IDLE);
    assign rsp_valid  = out_valid_reg;
    assign slot_free  = !out_valid_reg || rsp_ready;
    assign cmd.load   = req_valid && req_ready;
    assign cmd.commit = (state_reg == ST_EXEC) && slot_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hw/rtl/mrcf_dpath.sv
// ----------------------------------------------------------------------------
// mrcf_dpath
// Datapath: entry memory, ring pointers, per-reader state and the
// slowest-reader compare, plus the result register.
// ----------------------------------------------------------------------------
module mrcf_dpath
    import mrcf_pkg::*;
#(
    parameter int DEPTH   = 16,
    parameter int READERS = 8,
    parameter int WORD_W  = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctl_cmd_t  cmd,
    input  req_item_t req,
    output rsp_item_t rsp
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int DIST_W = $clog2(DEPTH + 1);
    localparam int RIDX_W = (READERS > 1) ? $clog2(READERS) : 1;

    function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
        begin
            ring_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        end
    endfunction

    // A reader level with the write pointer holds the whole ring unless it
    // has caught up.
    function automatic logic [DIST_W-1:0] ring_dist(
        input logic [PTR_W-1:0] wp,
        input logic [PTR_W-1:0] p,
        input logic             idle
    );
        logic [DIST_W-1:0] wx;
        logic [DIST_W-1:0] px;
        begin
            wx = DIST_W'(wp);
            px = DIST_W'(p);
            if (p == wp)
            begin
                ring_dist = idle ? '0 : DIST_W'(DEPTH);
            end
            else if (wp > p)
            begin
                ring_dist = wx - px;
            end
            else
            begin
                ring_dist = wx + DIST_W'(DEPTH) - px;
            end
        end
    endfunction

    // Shared state.
    logic [PTR_W-1:0]  write_ptr_reg, write_ptr_next;
    logic [PTR_W-1:0]  tail_ptr_reg, tail_ptr_next;
    logic              full_reg, full_next;
    logic              empty_reg, empty_next;
    logic [DIST_W-1:0] held_reg, held_next;
    logic [PTR_W-1:0]  rptr_reg [READERS];
    logic [PTR_W-1:0]  rptr_next [READERS];
    logic [READERS-1:0] ridle_reg, ridle_next;
    logic [READERS-1:0] ron_reg, ron_next;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              mem_we;

    // Captured transaction and values prepared at capture time.
    logic [OP_W-1:0]   op_reg;
    logic [RIDX_W-1:0] sidx_reg;
    logic              slot_ok_reg;
    logic [WORD_W-1:0] word_reg;
    logic [PTR_W-1:0]  np_reg;
    logic              np_idle_reg;
    logic [DIST_W-1:0] d_reg;

    rsp_item_t res_reg, res_next;

    // Capture-side logic, driven from the request payload.
    logic              in_ok;
    logic [RIDX_W-1:0] in_idx;
    logic [PTR_W-1:0]  cur_ptr;
    logic [PTR_W-1:0]  np;
    logic              np_idle;
    logic [PTR_W-1:0]  rd_addr;

    assign in_ok   = (32'(req.reader_slot) < READERS);
    assign in_idx  = RIDX_W'(req.reader_slot);
    assign cur_ptr = in_ok ? rptr_reg[in_idx] : tail_ptr_reg;
    assign np      = ring_inc(cur_ptr);
    assign np_idle = (np == write_ptr_reg);
    assign rd_addr = (req.operation == OP_PEEK) ? cur_ptr : tail_ptr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= req.operation;
            sidx_reg    <= in_idx;
            slot_ok_reg <= in_ok;
            word_reg    <= WORD_W'(req.push_word);
            np_reg      <= np;
            np_idle_reg <= np_idle;
            d_reg       <= ring_dist(write_ptr_reg, np, np_idle);
            rd_data_reg <= mem[rd_addr];
        end
        if (mem_we)
        begin
            mem[write_ptr_reg] <= word_reg;
        end
        if (cmd.commit)
        begin
            res_reg <= res_next;
        end
    end

    // One lane per reader: does another active reader lag further behind?
    logic [READERS-1:0] slower_vec;
    logic               active;

    always_comb
    begin
        for (int i = 0; i < READERS; i++)
        begin
            slower_vec[i] = ron_reg[i] && (RIDX_W'(i) != sidx_reg) &&
                (ring_dist(write_ptr_reg, rptr_reg[i], ridle_reg[i]) > d_reg);
        end
    end

    assign active = slot_ok_reg && ron_reg[sidx_reg];

    always_comb
    begin
        write_ptr_next = write_ptr_reg;
        tail_ptr_next  = tail_ptr_reg;
        full_next      = full_reg;
        empty_next     = empty_reg;
        held_next      = held_reg;
        rptr_next      = rptr_reg;
        ridle_next     = ridle_reg;
        ron_next       = ron_reg;
        mem_we         = 1'b0;
        res_next       = '0;
        res_next.status = ST_OK;

        unique case (op_reg)
            OP_PUSH:
            begin
                if (full_reg)
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    mem_we         = cmd.commit;
                    write_ptr_next = ring_inc(write_ptr_reg);
                    full_next      = (write_ptr_next == tail_ptr_reg);
                    empty_next     = 1'b0;
                    ridle_next     = ridle_reg & ~ron_reg;
                    held_next      = held_reg + DIST_W'(1);
                end
            end
            OP_PEEK:
            begin
                if (!active)
                begin
                    res_next.status = ST_INACTIVE;
                end
                else if (ridle_reg[sidx_reg])
                begin
                    res_next.status = ST_EMPTY;
                end
                else
                begin
                    res_next.word_valid = 1'b1;
                    res_next.out_word   = FIELD_W'(rd_data_reg);
                end
            end
            OP_ADVANCE:
            begin
                if (!active)
                begin
                    res_next.status = ST_INACTIVE;
                end
                else if (ridle_reg[sidx_reg])
                begin
                    res_next.status = ST_EMPTY;
                end
                else
                begin
                    rptr_next[sidx_reg]  = np_reg;
                    ridle_next[sidx_reg] = np_idle_reg;
                    if (slower_vec == '0)
                    begin
                        res_next.word_valid    = 1'b1;
                        res_next.tail_released = 1'b1;
                        res_next.out_word      = FIELD_W'(rd_data_reg);
                        tail_ptr_next          = ring_inc(tail_ptr_reg);
                        empty_next             = (tail_ptr_next == write_ptr_reg);
                        if (held_reg != '0)
                        begin
                            held_next = held_reg - DIST_W'(1);
                        end
                        full_next = 1'b0;
                    end
                end
            end
            OP_ADD:
            begin
                if (!slot_ok_reg)
                begin
                    res_next.status = ST_INACTIVE;
                end
                else
                begin
                    rptr_next[sidx_reg]  = tail_ptr_reg;
                    ridle_next[sidx_reg] = empty_reg;
                    ron_next[sidx_reg]   = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (!slot_ok_reg)
                begin
                    res_next.status = ST_INACTIVE;
                end
                else
                begin
                    ron_next[sidx_reg] = 1'b0;
                end
            end
            default:
            begin
                res_next.status = ST_OK;
            end
        endcase

        res_next.fill_level = LEVEL_W'(held_next);
        res_next.is_full    = full_next;
        res_next.is_empty   = empty_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_ptr_reg <= '0;
            tail_ptr_reg  <= '0;
            full_reg      <= 1'b0;
            empty_reg     <= 1'b1;
            held_reg      <= '0;
            ridle_reg     <= '1;
            ron_reg       <= '0;
            for (int i = 0; i < READERS; i++)
            begin
                rptr_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            write_ptr_reg <= write_ptr_next;
            tail_ptr_reg  <= tail_ptr_next;
            full_reg      <= full_next;
            empty_reg     <= empty_next;
            held_reg      <= held_next;
            ridle_reg     <= ridle_next;
            ron_reg       <= ron_next;
            rptr_reg      <= rptr_next;
        end
    end

    assign rsp = res_reg;

endmodule

FILE: hw/rtl/multi_reader_circular_fifo_core.sv
// Each transaction passes through capture (entry memory read, reader
// pointer step) and execute (compare against every reader lane, state update).
// Capture waits for the last transaction to leave execute; the result register
// frees the request side so the next transaction is taken while a result waits.
// Reset is asynchronous and leaves the ring empty with all readers inactive;
// no clearing pass is needed, and the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
// multi_reader_circular_fifo_core
// Broadcast circular FIFO with one writer and several reader slots.
// ----------------------------------------------------------------------------
`include "multi_reader_circular_fifo_core_macros.svh"

module multi_reader_circular_fifo_core
    import mrcf_pkg::*;
#(
    parameter int DEPTH   = 16,
    parameter int READERS = 8,
    parameter int WORD_W  = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    ctl_cmd_t cmd;

    mrcf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    mrcf_dpath #(
        .DEPTH   (DEPTH),
        .READERS (READERS),
        .WORD_W  (WORD_W)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

    // A captured transaction is always in execute on the following cycle.
    `MRCF_ASSERT_NXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready)

    // The ring cannot be full and empty at once, and full means a full count.
    `MRCF_ASSERT_IMP(a_full_level, clk, rst_n, rsp_valid && rsp.is_full, !rsp.is_empty && (rsp.fill_level == LEVEL_W'(DEPTH)))

    `MRCF_ASSERT_IMP(a_empty_level, clk, rst_n, rsp_valid && rsp.is_empty, rsp.fill_level == '0)

    // A released tail entry is always returned to the caller.
    `MRCF_ASSERT_IMP(a_release_word, clk, rst_n, rsp_valid && rsp.tail_released, rsp.word_valid && (rsp.status == ST_OK))

endmodule
